// ----- rtl/core/vrrq_pkg.sv -----
// Shared types and codes for the variable-length record ring queue.
// Has no dependencies; the top level and its parts import it.
package vrrq_pkg;

    // Values of the function select carried on the input tuser.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Control sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EMPTY = 3'b010,
        ST_POP   = 3'b100
    } vrrq_state_t;

endpackage

// ----- rtl/core/vrrq_store.sv -----
// Byte-wide record store: one write port and one read port, read data registered.
// Depends on vrrq_pkg only through the common import style; sized by its parameters.
module vrrq_store
    import vrrq_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/variable_record_ring_queue_top.sv -----
// Top level of the variable-length record ring queue: push/pop control and output register.
// Depends on vrrq_pkg (types, codes) and vrrq_store (record memory).
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata = push_byte, tuser = func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata = out_byte, tuser = is_empty,
//                                             tlast = last_byte
//
// A push item's byte is written to the store in the cycle it is accepted, so pushes
// stream at one item per cycle while the sequencer is idle.
// A pop item first reads the length byte from the store, then yields one result per
// cycle while m_axis does not stall, bounded by the store's single read port.
// An empty pop loads its single result via ST_EMPTY once the output register is free.
// Reset clears rp, wp, out_valid and sets wrap_reg to BUF_BYTES; the store is not cleared.
// While a pop streams, the input side is held off; a stalled m_axis holds the sequencer
// and the pending store read in place without losing data.
module variable_record_ring_queue_top
    import vrrq_pkg::*;
#(
    parameter int BUF_BYTES   = 1024,
    parameter int MAX_PAYLOAD = 50
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] push_byte
    input  logic       s_axis_tuser,   // [0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] is_empty
    output logic       m_axis_tlast
);

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int PTR_W  = $clog2(BUF_BYTES + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 3);

    localparam logic [SUM_W-1:0] BUF_S   = SUM_W'(BUF_BYTES);
    localparam logic [PTR_W-1:0] BUF_P   = PTR_W'(BUF_BYTES);
    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_PAYLOAD);

    vrrq_state_t state_reg, state_next;

    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] wrap_reg, wrap_next;
    logic [CNT_W-1:0] off_reg, off_next;
    logic [CNT_W-1:0] plen_reg, plen_next;

    // Pop sequencing
    logic [PTR_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] issue_k_reg, issue_k_next;
    logic [CNT_W-1:0] pend_k_reg, pend_k_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0] rlen_reg, rlen_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_empty_reg, out_empty_next;
    logic       out_last_reg, out_last_next;

    logic             in_fire;
    logic             push_fire;
    logic             pop_fire;
    logic [CNT_W-1:0] len_in;
    logic             wrap_now;
    logic [PTR_W-1:0] push_base;
    logic [SUM_W-1:0] push_addr_w;
    logic             push_done;
    logic [PTR_W-1:0] pop_base;
    logic             q_empty;

    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;

    logic [PTR_W-1:0] rd_base;
    logic [CNT_W-1:0] rd_k;
    logic [SUM_W-1:0] rd_sum;
    logic             out_free;
    logic             move;
    logic [CNT_W-1:0] rd_len_clamp;
    logic [CNT_W-1:0] len_eff;
    logic             is_last;
    logic             can_issue;
    logic [SUM_W-1:0] rp_end;

    vrrq_store #(
        .DEPTH  (BUF_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign push_fire     = in_fire && (s_axis_tuser == FUNC_PUSH);
    assign pop_fire      = in_fire && (s_axis_tuser == FUNC_POP);

    // Push address: a record that would run past the end restarts at zero.
    assign len_in    = (s_axis_tdata > 8'(MAX_PAYLOAD)) ? MAX_LEN : s_axis_tdata[CNT_W-1:0];
    assign wrap_now  = (off_reg == '0)
                    && (({1'b0, wp_reg} + SUM_W'(len_in) + SUM_W'(2)) > BUF_S);
    assign push_base = wrap_now ? '0 : wp_reg;
    assign push_addr_w = {1'b0, push_base} + SUM_W'(off_reg);
    assign push_done = (off_reg != '0)
                    && ((SUM_W'(off_reg) + SUM_W'(1)) >= (SUM_W'(plen_reg) + SUM_W'(2)));

    assign mem_we    = push_fire;
    assign mem_waddr = push_addr_w[ADDR_W-1:0];
    assign mem_wdata = (off_reg == '0) ? 8'(len_in) : s_axis_tdata;

    // Pop: empty test uses committed pointers; step over the wrap mark.
    assign q_empty  = (rp_reg == wp_reg);
    assign pop_base = (rp_reg == wrap_reg) ? '0 : rp_reg;

    // Store read index, folded once into range.
    assign rd_base   = (state_reg == ST_IDLE) ? pop_base : base_reg;
    assign rd_k      = (state_reg == ST_IDLE) ? '0 : issue_k_reg;
    assign rd_sum    = {1'b0, rd_base} + SUM_W'(rd_k);
    assign mem_raddr = (rd_sum >= BUF_S) ? ADDR_W'(rd_sum - BUF_S) : ADDR_W'(rd_sum);

    assign out_free     = !out_valid_reg || m_axis_tready;
    assign move         = (state_reg == ST_POP) && pend_valid_reg && out_free;
    assign rd_len_clamp = (mem_rdata > 8'(MAX_PAYLOAD)) ? MAX_LEN : mem_rdata[CNT_W-1:0];
    assign len_eff      = (pend_k_reg == '0) ? rd_len_clamp : rlen_reg;
    assign is_last      = (SUM_W'(pend_k_reg) == (SUM_W'(len_eff) + SUM_W'(1)));
    assign can_issue    = (SUM_W'(issue_k_reg) <= (SUM_W'(len_eff) + SUM_W'(1)))
                       && (!pend_valid_reg || move);
    assign mem_re       = (pop_fire && !q_empty) || ((state_reg == ST_POP) && can_issue);
    assign rp_end       = {1'b0, base_reg} + SUM_W'(len_eff) + SUM_W'(2);

    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        wrap_next       = wrap_reg;
        off_next        = off_reg;
        plen_next       = plen_reg;
        base_next       = base_reg;
        issue_k_next    = issue_k_reg;
        pend_k_next     = pend_k_reg;
        pend_valid_next = pend_valid_reg;
        rlen_next       = rlen_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (push_fire)
                begin
                    if (off_reg == '0)
                    begin
                        if (wrap_now)
                        begin
                            wrap_next = wp_reg;
                        end
                        wp_next   = push_base;
                        plen_next = len_in;
                        off_next  = CNT_W'(1);
                    end
                    else if (push_done)
                    begin
                        // Commit the record only after its last byte.
                        wp_next  = PTR_W'({1'b0, wp_reg} + SUM_W'(plen_reg) + SUM_W'(2));
                        off_next = '0;
                    end
                    else
                    begin
                        off_next = off_reg + CNT_W'(1);
                    end
                end
                else if (pop_fire)
                begin
                    if (q_empty)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next      = ST_POP;
                        base_next       = pop_base;
                        issue_k_next    = CNT_W'(1);
                        pend_k_next     = '0;
                        pend_valid_next = 1'b1;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_empty_next = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (move)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = (pend_k_reg == '0) ? 8'(rd_len_clamp) : mem_rdata;
                    out_empty_next = 1'b0;
                    out_last_next  = is_last;
                    if (pend_k_reg == '0)
                    begin
                        rlen_next = rd_len_clamp;
                    end
                    pend_valid_next = 1'b0;
                    if (is_last)
                    begin
                        // Advance past the record; fold back once past the end.
                        rp_next    = (rp_end > BUF_S) ? PTR_W'(rp_end - BUF_S) : PTR_W'(rp_end);
                        state_next = ST_IDLE;
                    end
                end
                if (can_issue)
                begin
                    pend_valid_next = 1'b1;
                    pend_k_next     = issue_k_reg;
                    issue_k_next    = issue_k_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            wrap_reg       <= BUF_P;
            off_reg        <= '0;
            plen_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            wrap_reg       <= wrap_next;
            off_reg        <= off_next;
            plen_reg       <= plen_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and sequencing registers carry no reset.
    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        issue_k_reg   <= issue_k_next;
        pend_k_reg    <= pend_k_next;
        rlen_reg      <= rlen_next;
        out_byte_reg  <= out_byte_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_empty_reg;
    assign m_axis_tlast  = out_last_reg;

    a_rp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= BUF_P)
        else $error("read pointer beyond buffer end");

    a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= BUF_P && wrap_reg <= BUF_P)
        else $error("write pointer or wrap mark beyond buffer end");

    a_push_addr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (push_addr_w < BUF_S))
        else $error("push address runs past the store");

    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_POP) |-> !pend_valid_reg)
        else $error("pending store read outside a pop");

    a_pop_end_free: assert property (@(posedge clk) disable iff (!rst_n)
        (move && is_last) |=> (state_reg == ST_IDLE && !pend_valid_reg))
        else $error("pop did not finish after its last byte");

endmodule

// ----- dv/variable_record_ring_queue_checker.sv -----
// Scoreboard for the variable-length record ring queue: mirrors the queue state from the
// accepted s_axis items, predicts every m_axis item and compares it as it is accepted.
// Depends on vrrq_pkg for the function codes.
module variable_record_ring_queue_checker
    import vrrq_pkg::*;
#(
    parameter int BUF_BYTES   = 1024,
    parameter int MAX_PAYLOAD = 50
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_data,    // [7:0] push_byte
    input  logic       in_user,    // [0] func
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_data,   // [7:0] out_byte
    input  logic       out_user,   // [0] is_empty
    input  logic       out_last,
    output int         failures,
    output int         pending_results,
    output logic       pop_safe
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = $clog2(BUF_BYTES) + 1;

    typedef struct packed {
        logic [7:0] data;
        logic       empty;
        logic       last;
    } queue_byte_t;

    logic [7:0]    mem_byte [BUF_BYTES];
    bit            mem_seen [BUF_BYTES];
    logic [PW-1:0] rd_ptr;
    logic [PW-1:0] wr_ptr;
    logic [PW-1:0] wrap_at;
    logic [5:0]    fill_off;
    logic [5:0]    fill_len;
    queue_byte_t   expected_bytes [$];
    int            mismatch_count = 0;
    int            result_count   = 0;

    assign failures = mismatch_count;

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int unsigned slot(input int unsigned p);
        return p % BUF_BYTES;
    endfunction

    function automatic logic [7:0] clamp_len(input logic [7:0] b);
        return (b > MAX_PAYLOAD) ? 8'(MAX_PAYLOAD) : b;
    endfunction

    // Write one record byte; the length byte decides a wrap before anything is written.
    function automatic void store_record_byte(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (fill_off == 0) begin
            v = clamp_len(b);
            if (wr_ptr + v + 2 > BUF_BYTES) begin
                wrap_at = wr_ptr;
                wr_ptr  = '0;
            end
            fill_len = v[5:0];
        end
        mem_byte[slot(wr_ptr + fill_off)] = v;
        mem_seen[slot(wr_ptr + fill_off)] = 1'b1;
        fill_off = 6'(fill_off + 1);
        if (fill_off >= fill_len + 2) begin
            wr_ptr   = PW'(wr_ptr + fill_len + 2);
            fill_off = '0;
        end
    endfunction

    // Queue the items of one pop: a single empty item, or the oldest record.
    function automatic void unload_record();
        queue_byte_t e;
        int unsigned len;
        int unsigned total;
        if (rd_ptr == wr_ptr) begin
            e.data  = 8'h00;
            e.empty = 1'b1;
            e.last  = 1'b1;
            expected_bytes.push_back(e);
            return;
        end
        if (rd_ptr == wrap_at)
            rd_ptr = '0;
        len   = clamp_len(mem_byte[slot(rd_ptr)]);
        total = len + 2;
        for (int unsigned k = 0; k < total; k++) begin
            e.data  = (k == 0) ? 8'(len) : mem_byte[slot(rd_ptr + k)];
            e.empty = 1'b0;
            e.last  = (k + 1 == total);
            expected_bytes.push_back(e);
        end
        rd_ptr = PW'(rd_ptr + total);
        if (rd_ptr > BUF_BYTES)
            rd_ptr = PW'(rd_ptr - BUF_BYTES);
    endfunction

    // A pop now would touch only store entries that have been written.
    function automatic logic pop_reads_written();
        int unsigned base;
        int unsigned len;
        if (rd_ptr == wr_ptr)
            return 1'b1;
        base = (rd_ptr == wrap_at) ? 0 : rd_ptr;
        if (!mem_seen[slot(base)])
            return 1'b0;
        len = clamp_len(mem_byte[slot(base)]);
        for (int unsigned k = 1; k < len + 2; k++)
            if (!mem_seen[slot(base + k)])
                return 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        queue_byte_t want;
        if (!rst_n) begin
            rd_ptr   = '0;
            wr_ptr   = '0;
            wrap_at  = PW'(BUF_BYTES);
            fill_off = '0;
            fill_len = '0;
            for (int i = 0; i < BUF_BYTES; i++)
                mem_seen[i] = 1'b0;
            expected_bytes.delete();
            pop_safe        <= 1'b1;
            pending_results <= 0;
        end
        else begin
            // Compare before predicting: a new item's results always come later.
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0)
                    flag_mismatch($sformatf("unexpected item %0d: data=%02h empty=%0b last=%0b",
                                            result_count, out_data, out_user, out_last));
                else begin
                    want = expected_bytes.pop_front();
                    if (out_data !== want.data || out_user !== want.empty
                        || out_last !== want.last)
                        flag_mismatch($sformatf(
                            "item %0d: got data=%02h empty=%0b last=%0b, want %02h %0b %0b",
                            result_count, out_data, out_user, out_last,
                            want.data, want.empty, want.last));
                end
                result_count++;
            end
            if (in_valid && in_ready) begin
                if (in_user == FUNC_PUSH)
                    store_record_byte(in_data);
                else
                    unload_record();
            end
            pop_safe        <= pop_reads_written();
            pending_results <= expected_bytes.size();
        end
    end

endmodule

// ----- dv/variable_record_ring_queue_top_tb.sv -----
// Testbench top for the variable-length record ring queue: drives record bytes and pops,
// randomly stalls both channels and gives the verdict.
// Depends on vrrq_pkg, variable_record_ring_queue_top and variable_record_ring_queue_checker.
module variable_record_ring_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vrrq_pkg::*;

    localparam int BUF_BYTES      = 1024;
    localparam int MAX_PAYLOAD    = 50;
    localparam int IDLE_PCT       = 38;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 64;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] push_byte
    logic       s_axis_tuser;    // [0] func
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic       m_axis_tuser;    // [0] is_empty
    logic       m_axis_tlast;

    int          failures;
    int          pending_results;
    logic        pop_safe;
    logic        steady;           // high: neither side idles
    int unsigned bytes_pushed;
    int unsigned quiet_cycles = 0;

    variable_record_ring_queue_top #(
        .BUF_BYTES   (BUF_BYTES),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    variable_record_ring_queue_checker #(
        .BUF_BYTES   (BUF_BYTES),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) record_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_data         (s_axis_tdata),
        .in_user         (s_axis_tuser),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (m_axis_tdata),
        .out_user        (m_axis_tuser),
        .out_last        (m_axis_tlast),
        .failures        (failures),
        .pending_results (pending_results),
        .pop_safe        (pop_safe)
    );

    // 4 ns clock.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Receiver: stall about 38 percent of the time, never during the steady stretch.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("variable_record_ring_queue_top_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one item, starting and ending at a falling edge. Valid stays high
    // into the next item unless an idle gap or a pause lowers it.
    task automatic send_item(input logic f, input logic [7:0] b);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (f == FUNC_PUSH)
            bytes_pushed++;
        @(negedge clk);
    endtask

    // Pop only where the pop reads store entries that hold written data.
    task automatic try_pop();
        if (pop_safe)
            send_item(FUNC_POP, 8'($urandom_range(255)));
    endtask

    // Hold the sender off until every predicted item has come out.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // Push a whole record: length byte, type byte, payload; optionally slip pops in.
    task automatic push_record(input logic [7:0] len_byte, input int unsigned mid_pop_pct);
        int unsigned body;
        body = ((len_byte > MAX_PAYLOAD) ? MAX_PAYLOAD : len_byte) + 1;
        send_item(FUNC_PUSH, len_byte);
        repeat (body) begin
            if ($urandom_range(99) < mid_pop_pct)
                try_pop();
            send_item(FUNC_PUSH, 8'($urandom_range(255)));
        end
    endtask

    // Short records most often, many near the limit, some above it to be clamped.
    function automatic logic [7:0] draw_length();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return 8'($urandom_range(7));
        if (pick < 70)
            return 8'($urandom_range(MAX_PAYLOAD, MAX_PAYLOAD - 10));
        if (pick < 85)
            return 8'($urandom_range(255, MAX_PAYLOAD + 1));
        if (pick < 90)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    initial begin
        int unsigned rec_no;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = FUNC_PUSH;
        steady        = 1'b0;
        bytes_pushed  = 0;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: pop an empty queue right after reset.
        try_pop();
        // Empty record with an all-ones type byte.
        send_item(FUNC_PUSH, 8'h00);
        send_item(FUNC_PUSH, 8'hFF);
        // Short record with zero and all-ones payload bytes.
        send_item(FUNC_PUSH, 8'h03);
        send_item(FUNC_PUSH, 8'h00);
        send_item(FUNC_PUSH, 8'h00);
        send_item(FUNC_PUSH, 8'hFF);
        send_item(FUNC_PUSH, 8'hA5);
        // Drain both, then hit empty again.
        try_pop();
        try_pop();
        try_pop();
        // Pop in the middle of a record: the uncommitted record stays invisible.
        send_item(FUNC_PUSH, 8'h02);
        send_item(FUNC_PUSH, 8'h5A);
        try_pop();
        send_item(FUNC_PUSH, 8'h00);
        send_item(FUNC_PUSH, 8'hFF);
        try_pop();
        pause_until_drained();

        // Random, keeping up with the writer; a window in the middle runs with no idling.
        rec_no = 0;
        while (bytes_pushed < 120) begin
            steady = (bytes_pushed >= 30 && bytes_pushed < 90);
            if ($urandom_range(99) < 8) begin
                // noise: a stray byte or pop that can break record framing
                if ($urandom_range(1) == 1)
                    try_pop();
                else
                    send_item(FUNC_PUSH, 8'($urandom_range(255)));
            end
            else begin
                push_record(draw_length(), 4);
                if ($urandom_range(99) < 85)
                    try_pop();
                if ($urandom_range(99) < 20)
                    try_pop();
            end
            rec_no++;
        end
        steady = 1'b0;
        pause_until_drained();

        // Long records back to back with no pops, then pop through whatever the
        // pointers now select.
        repeat (2)
            push_record(8'($urandom_range(MAX_PAYLOAD, MAX_PAYLOAD - 10)), 0);
        repeat (4)
            try_pop();
        pause_until_drained();

        // Mixed tail with frequent pops inside records.
        repeat (2) begin
            push_record(draw_length(), 20);
            if ($urandom_range(99) < 70)
                try_pop();
        end
        repeat (4)
            try_pop();

        // Drain, then give the block time to show any stray item.
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0 && pending_results == 0)
            $display("variable_record_ring_queue_top_tb: PASS");
        else
            $display("variable_record_ring_queue_top_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/vrrq_pkg.sv
rtl/core/vrrq_store.sv
rtl/core/variable_record_ring_queue_top.sv
dv/variable_record_ring_queue_checker.sv
dv/variable_record_ring_queue_top_tb.sv
